FILE: design/hvn_pkg.sv
// Shared types, constants and helper functions of the heightmap vertex normal block.
package hvn_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int HGT_W      = 16;
    localparam int DIFF_W     = 18;
    localparam int PROD_W     = 31;
    localparam int MAG_W      = 24;
    localparam int SQ_W       = 48;
    localparam int SUM_W      = 49;
    localparam int QUO_W      = 32;
    localparam int PQ_W       = 16;
    localparam int POS_W      = 17;
    localparam int NRM_W      = 16;
    localparam int NY_W       = 15;
    localparam int DIV_STEPS  = QUO_W;
    localparam int POS_STEPS  = PQ_W;
    localparam int SQRT_STEPS = QUO_W / 2;

    localparam logic [MAG_W-1:0] GRAD_SAT = {MAG_W{1'b1}};
    localparam logic [SUM_W-1:0] UNIT_SQ  = SUM_W'(512 * 512);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(65536);
    localparam logic [NY_W-1:0]  NRM_MAX  = {NY_W{1'b1}};

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_idx_t;

    // Data that rides along with an item through the arithmetic.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [HGT_W-1:0]   pos_y;
        logic [DIM_W-1:0]   tex_v;
        logic               sat_x;
        logic               sat_z;
        logic [COORD_W-1:0] span_w;
        logic [COORD_W-1:0] span_h;
        logic               neg_x;
        logic               neg_z;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [SUM_W-1:0]   s;
        logic [SUM_W-1:0]   rem_x;
        logic [SUM_W-1:0]   rem_y;
        logic [SUM_W-1:0]   rem_z;
        logic [QUO_W-1:0]   q_x;
        logic [QUO_W-1:0]   q_y;
        logic [QUO_W-1:0]   q_z;
        logic [COORD_W-1:0] prem_x;
        logic [COORD_W-1:0] prem_z;
        logic [PQ_W-1:0]    pq_x;
        logic [PQ_W-1:0]    pq_z;
    } div_t;

    typedef struct packed {
        side_t            side;
        logic [PQ_W-1:0]  pq_x;
        logic [PQ_W-1:0]  pq_z;
        logic [QUO_W-1:0] v_x;
        logic [QUO_W-1:0] v_y;
        logic [QUO_W-1:0] v_z;
        logic [QUO_W-1:0] r_x;
        logic [QUO_W-1:0] r_y;
        logic [QUO_W-1:0] r_z;
    } sq_t;

    // Dimension clamped to [2, MAX_DIM], minus one.
    function automatic logic [COORD_W-1:0] eff_span(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] t;
        begin
            if (d < DIM_W'(2)) t = DIM_W'(2);
            else if (d > DIM_W'(MAX_DIM)) t = DIM_W'(MAX_DIM);
            else t = d;
            eff_span = COORD_W'(t - DIM_W'(1));
        end
    endfunction

    // Central difference inside, doubled one-sided difference at the edges.
    function automatic logic signed [DIFF_W-1:0] edge_diff(
        input logic [COORD_W-1:0]      c,
        input logic [COORD_W-1:0]      span,
        input logic signed [HGT_W-1:0] p,
        input logic signed [HGT_W-1:0] prev,
        input logic signed [HGT_W-1:0] next
    );
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        begin
            if (c == '0) begin
                a = DIFF_W'(next);
                b = DIFF_W'(p);
                edge_diff = (a - b) <<< 1;
            end else if (c >= span) begin
                a = DIFF_W'(p);
                b = DIFF_W'(prev);
                edge_diff = (a - b) <<< 1;
            end else begin
                a = DIFF_W'(next);
                b = DIFF_W'(prev);
                edge_diff = a - b;
            end
        end
    endfunction

    function automatic logic [MAG_W-1:0] sat_mag(input logic signed [PROD_W-1:0] g);
        logic [PROD_W-1:0] a;
        begin
            a = g[PROD_W-1] ? PROD_W'(-g) : PROD_W'(g);
            sat_mag = (a > PROD_W'(GRAD_SAT)) ? GRAD_SAT : a[MAG_W-1:0];
        end
    endfunction

endpackage

FILE: design/heightmap_vertex_normal.sv
// Top level of the heightmap vertex normal block: config, pipeline and output skid.
//
// One terrain vertex per request, one request per clock while s_ready is high. A
// vertex passes 6 front stages (clamp, difference, scale by span, saturate, square,
// sum), 32 stages of the restoring divider that forms each normal component's
// squared ratio (the grid position quotients ride in its first 16 stages),
// 16 stages of the square root, and the output register. The divider's
// 32 quotient bits set the depth. A two-entry output (register plus skid)
// keeps s_ready registered: the pipeline only freezes once the skid fills.
// grid_width and grid_height are sampled as a request enters, so change
// them only with the block empty. Values below 2 act as 2, above 4096 as 4096.
module heightmap_vertex_normal import hvn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // config writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [DIM_W-1:0]   cfg_data,
    // request in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_col,
    input  logic [COORD_W-1:0] s_row,
    input  logic [HGT_W-1:0]   s_center_height,
    input  logic [HGT_W-1:0]   s_left_height,
    input  logic [HGT_W-1:0]   s_right_height,
    input  logic [HGT_W-1:0]   s_up_height,
    input  logic [HGT_W-1:0]   s_down_height,
    // vertex out
    output logic               m_valid,
    input  logic               m_ready,
    output logic [POS_W-1:0]   m_pos_x,
    output logic [HGT_W-1:0]   m_pos_y,
    output logic [POS_W-1:0]   m_pos_z,
    output logic [NRM_W-1:0]   m_normal_x,
    output logic [NY_W-1:0]    m_normal_y,
    output logic [NRM_W-1:0]   m_normal_z,
    output logic [COORD_W-1:0] m_tex_u,
    output logic [DIM_W-1:0]   m_tex_v
);

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [HGT_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [NRM_W-1:0]   normal_x;
        logic [NY_W-1:0]    normal_y;
        logic [NRM_W-1:0]   normal_z;
        logic [COORD_W-1:0] tex_u;
        logic [DIM_W-1:0]   tex_v;
    } vtx_t;

    logic [DIM_W-1:0] grid_width_reg, grid_height_reg;
    logic             skid_full_reg, m_valid_reg;
    vtx_t             out_reg, skid_reg, vtx;
    logic             en;
    logic             front_valid, div_valid, sq_valid;
    div_t             front_data, div_data;
    sq_t              sq_data;

    // Round root/2 to nearest, clip to Q1.15 max.
    function automatic logic [NY_W-1:0] round_half(input logic [QUO_W-1:0] r);
        logic [PQ_W:0] t;
        begin
            t = {1'b0, r[PQ_W-1:0]} + (PQ_W+1)'(1);
            round_half = (t[PQ_W:1] > PQ_W'(NRM_MAX)) ? NRM_MAX : t[NY_W:1];
        end
    endfunction

    function automatic logic [NRM_W-1:0] apply_sign(input logic [NY_W-1:0] n,
                                                    input logic neg);
        begin
            apply_sign = neg ? NRM_W'(-{1'b0, n}) : {1'b0, n};
        end
    endfunction

    // config registers; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= DIM_W'(256);
            grid_height_reg <= DIM_W'(256);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together until the skid holds a vertex.
    assign en      = !skid_full_reg;
    assign s_ready = en;

    hvn_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .col           (s_col),
        .row           (s_row),
        .center_height (s_center_height),
        .left_height   (s_left_height),
        .right_height  (s_right_height),
        .up_height     (s_up_height),
        .down_height   (s_down_height),
        .grid_width    (grid_width_reg),
        .grid_height   (grid_height_reg),
        .out_valid     (front_valid),
        .out_data      (front_data)
    );

    hvn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    hvn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    // final rounding, sign and position saturation
    always_comb begin
        vtx.pos_x    = sq_data.side.sat_x ? POS_ONE : {1'b0, sq_data.pq_x};
        vtx.pos_z    = sq_data.side.sat_z ? POS_ONE : {1'b0, sq_data.pq_z};
        vtx.pos_y    = sq_data.side.pos_y;
        vtx.normal_x = apply_sign(round_half(sq_data.r_x), sq_data.side.neg_x);
        vtx.normal_y = round_half(sq_data.r_y);
        vtx.normal_z = apply_sign(round_half(sq_data.r_z), sq_data.side.neg_z);
        vtx.tex_u    = sq_data.side.col;
        vtx.tex_v    = sq_data.side.tex_v;
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg   <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end else if (sq_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (!m_valid_reg || m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (sq_valid) begin
            if (!m_valid_reg || m_ready) begin
                out_reg <= vtx;
            end else begin
                skid_reg <= vtx;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pos_x    = out_reg.pos_x;
    assign m_pos_y    = out_reg.pos_y;
    assign m_pos_z    = out_reg.pos_z;
    assign m_normal_x = out_reg.normal_x;
    assign m_normal_y = out_reg.normal_y;
    assign m_normal_z = out_reg.normal_z;
    assign m_tex_u    = out_reg.tex_u;
    assign m_tex_v    = out_reg.tex_v;

    // skid only ever holds a vertex behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid full without output valid");

    // a full skid drains into the output, never leaving it empty
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && m_ready) |=> (m_valid_reg && !skid_full_reg))
        else $error("skid drain lost a vertex");

    // a blocked output keeps the skid occupied
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && !m_ready) |=> skid_full_reg)
        else $error("skid dropped while output stalled");

    // nothing leaves the pipeline while it is frozen
    a_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && !m_ready) |=> $stable(out_reg))
        else $error("output changed while pipeline frozen");

endmodule

FILE: design/hvn_front.sv
// Front stages: clamps, gradients, saturation, squares and divider setup.
module hvn_front import hvn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [HGT_W-1:0]   center_height,
    input  logic [HGT_W-1:0]   left_height,
    input  logic [HGT_W-1:0]   right_height,
    input  logic [HGT_W-1:0]   up_height,
    input  logic [HGT_W-1:0]   down_height,
    input  logic [DIM_W-1:0]   grid_width,
    input  logic [DIM_W-1:0]   grid_height,
    output logic               out_valid,
    output div_t               out_data
);

    logic [5:0] vld_reg;

    // stage 1
    logic [COORD_W-1:0] col1_reg, row1_reg, spw1_reg, sph1_reg;
    logic [HGT_W-1:0]   p1_reg, l1_reg, r1_reg, u1_reg, d1_reg;
    // stage 2
    side_t                    side2_reg;
    logic signed [DIFF_W-1:0] dx2_reg, dz2_reg;
    side_t                    side2_next;
    // stage 3
    side_t                    side3_reg;
    logic signed [PROD_W-1:0] gx3_reg, gz3_reg;
    // stage 4
    side_t                    side4_reg, side4_next;
    logic [MAG_W-1:0]         mx4_reg, mz4_reg;
    // stage 5
    side_t                    side5_reg;
    logic [SQ_W-1:0]          sx5_reg, sz5_reg;
    // stage 6
    div_t                     div6_reg, div6_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_comb begin
        side2_next        = '0;
        side2_next.col    = col1_reg;
        side2_next.row    = row1_reg;
        side2_next.pos_y  = p1_reg;
        side2_next.span_w = spw1_reg;
        side2_next.span_h = sph1_reg;
        side2_next.sat_x  = (col1_reg >= spw1_reg);
        side2_next.sat_z  = (row1_reg >= sph1_reg);
        side2_next.tex_v  = (row1_reg > sph1_reg) ? '0
                          : DIM_W'({1'b0, sph1_reg} + DIM_W'(1) - {1'b0, row1_reg});
    end

    // normal sign is negative where the gradient is not negative
    always_comb begin
        side4_next       = side3_reg;
        side4_next.neg_x = !gx3_reg[PROD_W-1];
        side4_next.neg_z = !gz3_reg[PROD_W-1];
    end

    always_comb begin
        div6_next        = '0;
        div6_next.side   = side5_reg;
        div6_next.s      = SUM_W'(sx5_reg) + SUM_W'(sz5_reg) + UNIT_SQ;
        div6_next.rem_x  = SUM_W'(sx5_reg);
        div6_next.rem_y  = UNIT_SQ;
        div6_next.rem_z  = SUM_W'(sz5_reg);
        div6_next.prem_x = side5_reg.sat_x ? '0 : side5_reg.col;
        div6_next.prem_z = side5_reg.sat_z ? '0 : side5_reg.row;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col1_reg <= col;
            row1_reg <= row;
            spw1_reg <= eff_span(grid_width);
            sph1_reg <= eff_span(grid_height);
            p1_reg   <= center_height;
            l1_reg   <= left_height;
            r1_reg   <= right_height;
            u1_reg   <= up_height;
            d1_reg   <= down_height;

            side2_reg <= side2_next;
            dx2_reg   <= edge_diff(col1_reg, spw1_reg, p1_reg, l1_reg, r1_reg);
            dz2_reg   <= edge_diff(row1_reg, sph1_reg, p1_reg, u1_reg, d1_reg);

            side3_reg <= side2_reg;
            gx3_reg   <= dx2_reg * $signed({1'b0, side2_reg.span_w});
            gz3_reg   <= dz2_reg * $signed({1'b0, side2_reg.span_h});

            side4_reg <= side4_next;
            mx4_reg   <= sat_mag(gx3_reg);
            mz4_reg   <= sat_mag(gz3_reg);

            side5_reg <= side4_reg;
            sx5_reg   <= mx4_reg * mx4_reg;
            sz5_reg   <= mz4_reg * mz4_reg;

            div6_reg <= div6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = div6_reg;

endmodule

FILE: design/hvn_div.sv
// Restoring divider pipeline: normal ratios and grid positions, one bit per stage.
module hvn_div import hvn_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    div_t                 stage_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        div_t               cur;
        div_t               stage_next;
        logic [SUM_W:0]     sh_x, sh_y, sh_z;
        logic [COORD_W:0]   psh_x, psh_z;
        logic [COORD_W-2:0] half_w, half_h;

        if (k == 0) begin : g_first
            assign cur = in_data;
        end else begin : g_rest
            assign cur = stage_reg[k-1];
        end

        assign half_w = cur.side.span_w[COORD_W-1:1];
        assign half_h = cur.side.span_h[COORD_W-1:1];

        always_comb begin
            stage_next = cur;
            sh_x = {cur.rem_x, 1'b0};
            sh_y = {cur.rem_y, 1'b0};
            sh_z = {cur.rem_z, 1'b0};
            stage_next.q_x = {cur.q_x[QUO_W-2:0], sh_x >= {1'b0, cur.s}};
            stage_next.q_y = {cur.q_y[QUO_W-2:0], sh_y >= {1'b0, cur.s}};
            stage_next.q_z = {cur.q_z[QUO_W-2:0], sh_z >= {1'b0, cur.s}};
            stage_next.rem_x = (sh_x >= {1'b0, cur.s}) ? SUM_W'(sh_x - {1'b0, cur.s})
                                                      : SUM_W'(sh_x);
            stage_next.rem_y = (sh_y >= {1'b0, cur.s}) ? SUM_W'(sh_y - {1'b0, cur.s})
                                                      : SUM_W'(sh_y);
            stage_next.rem_z = (sh_z >= {1'b0, cur.s}) ? SUM_W'(sh_z - {1'b0, cur.s})
                                                      : SUM_W'(sh_z);
            psh_x = '0;
            psh_z = '0;
            // Position numerator is coord * 65536 + span / 2; its low bits feed in here.
            if (k < POS_STEPS) begin
                psh_x = {cur.prem_x, (POS_STEPS - 1 - k < COORD_W - 1) ?
                         half_w[(POS_STEPS - 1 - k) % (COORD_W - 1)] : 1'b0};
                psh_z = {cur.prem_z, (POS_STEPS - 1 - k < COORD_W - 1) ?
                         half_h[(POS_STEPS - 1 - k) % (COORD_W - 1)] : 1'b0};
                stage_next.pq_x = {cur.pq_x[PQ_W-2:0], psh_x >= {1'b0, cur.side.span_w}};
                stage_next.pq_z = {cur.pq_z[PQ_W-2:0], psh_z >= {1'b0, cur.side.span_h}};
                stage_next.prem_x = (psh_x >= {1'b0, cur.side.span_w}) ?
                    COORD_W'(psh_x - {1'b0, cur.side.span_w}) : COORD_W'(psh_x);
                stage_next.prem_z = (psh_z >= {1'b0, cur.side.span_h}) ?
                    COORD_W'(psh_z - {1'b0, cur.side.span_h}) : COORD_W'(psh_z);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_data  = stage_reg[DIV_STEPS-1];

endmodule

FILE: design/hvn_sqrt.sv
// Integer square root pipeline for the three normal components, two bits per stage.
module hvn_sqrt import hvn_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output sq_t  out_data
);

    sq_t                   stage_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vld_reg;
    sq_t                   first;

    always_comb begin
        first      = '0;
        first.side = in_data.side;
        first.pq_x = in_data.pq_x;
        first.pq_z = in_data.pq_z;
        first.v_x  = in_data.q_x;
        first.v_y  = in_data.q_y;
        first.v_z  = in_data.q_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        localparam logic [QUO_W-1:0] BIT = QUO_W'(1) << (QUO_W - 2 - 2 * k);
        sq_t            cur;
        sq_t            stage_next;
        logic [QUO_W:0] t_x, t_y, t_z;

        if (k == 0) begin : g_first
            assign cur = first;
        end else begin : g_rest
            assign cur = stage_reg[k-1];
        end

        always_comb begin
            stage_next = cur;
            t_x = {1'b0, cur.r_x} + {1'b0, BIT};
            t_y = {1'b0, cur.r_y} + {1'b0, BIT};
            t_z = {1'b0, cur.r_z} + {1'b0, BIT};
            if ({1'b0, cur.v_x} >= t_x) begin
                stage_next.v_x = QUO_W'({1'b0, cur.v_x} - t_x);
                stage_next.r_x = (cur.r_x >> 1) + BIT;
            end else begin
                stage_next.r_x = cur.r_x >> 1;
            end
            if ({1'b0, cur.v_y} >= t_y) begin
                stage_next.v_y = QUO_W'({1'b0, cur.v_y} - t_y);
                stage_next.r_y = (cur.r_y >> 1) + BIT;
            end else begin
                stage_next.r_y = cur.r_y >> 1;
            end
            if ({1'b0, cur.v_z} >= t_z) begin
                stage_next.v_z = QUO_W'({1'b0, cur.v_z} - t_z);
                stage_next.r_z = (cur.r_z >> 1) + BIT;
            end else begin
                stage_next.r_z = cur.r_z >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_data  = stage_reg[SQRT_STEPS-1];

endmodule
